// ===== rtl/ethernet_learning_switch_forwarder_macros.svh =====
// assertion macros for the learning switch forwarder checker
// used by elsf_checker.sv only
`ifndef ETHERNET_LEARNING_SWITCH_FORWARDER_MACROS_SVH
`define ETHERNET_LEARNING_SWITCH_FORWARDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define ELSF_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("elsf check failed");

// next-cycle implication, disabled in reset
`define ELSF_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("elsf check failed");

`endif

// ===== rtl/elsf_pkg.sv =====
// types, codes and helpers shared by the switch forwarder files
// no dependencies
`timescale 1ns / 1ps

package elsf_pkg;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_ADD    = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ROUTED   = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_ADDED    = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_TICK     = 3'd6,
    ST_AGED     = 3'd7
  } status_t;

  localparam logic [1:0] REG_SWITCHING = 2'd0;
  localparam logic [1:0] REG_MAX_LEN   = 2'd1;
  localparam logic [1:0] REG_AGE_LIMIT = 2'd2;

  localparam int unsigned MAX_PORTS        = 8;
  localparam int unsigned SCAN_INTERVAL_MS = 1000;
  localparam logic [15:0] MIN_FRAME_LEN    = 16'd14;
  localparam int unsigned GROUP_BIT        = 40;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 80;

  typedef struct packed {
    logic [47:0] mac;
    logic [2:0]  port;
    logic [31:0] seen;
  } entry_t;

  function automatic logic [7:0] flood_mask(input logic [7:0] ready, input logic [3:0] pc,
                                            input logic src_ok, input logic [2:0] sel);
    logic [7:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[i] = ready[i] && (4'(i) < pc) && !(src_ok && (3'(i) == sel));
    end
    return m;
  endfunction

endpackage

// ===== rtl/elsf_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module elsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ethernet_learning_switch_forwarder.sv =====
// layer-2 learning switch forwarder: mac table in ram, valid bits in flops
// depends on elsf_pkg and elsf_ram
`timescale 1ns / 1ps

// Usage:
// s_* takes one request per item: s_tuser is the command (frame, tick, add
// port, remove port), s_tdata carries the frame fields. m_* returns exactly
// one result per request: m_tuser is the status, m_tdata the delivery mask,
// new port index, live port count and the routed and dropped totals.
// cfg_we/cfg_index/cfg_data write the switching enable, the length limit and
// the age limit; write only while the block is idle.
// Flow: a request that needs no table pass (bad length, hub mode, plain
// tick, add, refused remove) goes from idle straight to the done state. A
// switched frame, an aging tick and a remove walk the table ram once, one
// entry per cycle, then pass the finish state before done. The block
// holds one request at a time; s_tready is high while it is idle.
// Reset clears the table valid bits, the port count, the clock and the
// totals and loads the register defaults; no clearing pass is needed.
// A stalled m_tready holds the result; the block finishes its work and
// then waits before taking the next request.

module ethernet_learning_switch_forwarder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // port_sel, src_known, dst_mac, src_mac, frame_len, ready_mask, zero pad
  input  logic [127:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // deliver_mask, new_port, live_ports, routed_count, dropped_count, zero pad
  output logic [79:0]  m_tdata,
  // status
  output logic [2:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import elsf_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  logic        sw_en;
  logic [13:0] max_len;
  logic [31:0] age_limit;
  logic [3:0]  port_count;
  logic [31:0] clock_ms, last_scan, routed_total, dropped_total;
  logic [TABLE_ENTRIES-1:0] valid_bits;

  cmd_t        it_cmd;
  logic [2:0]  it_sel;
  logic        it_src_ok, it_learn, it_lookup;
  logic [47:0] it_dst, it_src;
  logic [7:0]  it_ready;

  status_t     res_status;
  logic [7:0]  res_deliver;
  logic [2:0]  res_new;

  logic [CW-1:0] cnt;
  logic          p_valid;
  logic [IW-1:0] p_idx;

  logic          m_found, e_found, o_found, d_found;
  logic [IW-1:0] m_idx, e_idx, o_idx, d_idx;
  logic [31:0]   o_age;
  logic [2:0]    d_port;

  entry_t        rd_entry, wr_entry;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;

  // input fields
  cmd_t        in_cmd;
  logic [2:0]  in_sel;
  logic        in_known;
  logic [47:0] in_dst, in_src;
  logic [15:0] in_len;
  logic [7:0]  in_ready;
  logic        in_src_ok;
  logic [31:0] clock_next;
  logic        in_len_ok, in_aging, in_scan;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_sel    = s_tdata[2:0];
  assign in_known  = s_tdata[3];
  assign in_dst    = s_tdata[51:4];
  assign in_src    = s_tdata[99:52];
  assign in_len    = s_tdata[115:100];
  assign in_ready  = s_tdata[123:116];
  assign in_src_ok = in_known && ({1'b0, in_sel} < port_count);
  assign clock_next = clock_ms + 32'd1;
  assign in_len_ok = !(in_len < MIN_FRAME_LEN || in_len > {2'b00, max_len});
  assign in_aging  = (clock_next - last_scan) >= 32'(SCAN_INTERVAL_MS);
  assign in_scan   = (in_cmd == CMD_FRAME && in_len_ok && sw_en) ||
                     (in_cmd == CMD_TICK && in_aging) ||
                     (in_cmd == CMD_REMOVE && ({1'b0, in_sel} < port_count));

  assign s_tready = (state == S_IDLE);

  // per-entry view during the pass
  logic        cur_v;
  logic [31:0] cur_age;
  assign cur_v   = p_valid && valid_bits[p_idx];
  assign cur_age = clock_ms - rd_entry.seen;

  // learn slot and lookup after learning
  logic          slot_ok, slot_new;
  logic [IW-1:0] slot;
  logic          hit;
  logic [2:0]    hit_port;
  logic [7:0]    fin_deliver;

  always_comb begin
    slot_ok  = it_learn && (m_found || e_found || o_found);
    slot_new = slot_ok && !m_found;
    slot     = m_found ? m_idx : (e_found ? e_idx : o_idx);
    hit      = 1'b0;
    hit_port = d_port;
    if (it_lookup) begin
      if (it_learn && m_found) begin
        hit      = d_found;
        hit_port = (d_idx == m_idx) ? it_sel : d_port;
      end else if (slot_new) begin
        if (it_src == it_dst) begin
          hit      = 1'b1;
          hit_port = it_sel;
        end else begin
          hit = d_found && (d_idx != slot);
        end
      end else begin
        hit = d_found;
      end
    end
    if (hit && ({1'b0, hit_port} < port_count)) begin
      if ((it_src_ok && hit_port == it_sel) || !it_ready[hit_port]) begin
        fin_deliver = '0;
      end else begin
        fin_deliver = 8'b1 << hit_port;
      end
    end else begin
      fin_deliver = flood_mask(it_ready, port_count, it_src_ok, it_sel);
    end
  end

  // ram write: renumbering during a remove pass, or the learned entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    wr_entry  = rd_entry;
    if (state == S_SCAN && it_cmd == CMD_REMOVE && cur_v && rd_entry.port > it_sel) begin
      ram_we        = 1'b1;
      wr_entry.port = rd_entry.port - 3'd1;
    end else if (state == S_FIN && it_cmd == CMD_FRAME && slot_ok) begin
      ram_we        = 1'b1;
      ram_waddr     = slot;
      wr_entry.mac  = it_src;
      wr_entry.port = it_sel;
      wr_entry.seen = clock_ms;
    end
  end

  elsf_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(cnt[IW-1:0]),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sw_en         <= 1'b1;
      max_len       <= 14'd1522;
      age_limit     <= 32'd300000;
      port_count    <= '0;
      clock_ms      <= '0;
      last_scan     <= '0;
      routed_total  <= '0;
      dropped_total <= '0;
      valid_bits    <= '0;
      m_tvalid      <= 1'b0;
      p_valid       <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SWITCHING: sw_en     <= cfg_data[0];
          REG_MAX_LEN:   max_len   <= cfg_data[13:0];
          REG_AGE_LIMIT: age_limit <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            it_cmd      <= in_cmd;
            it_sel      <= in_sel;
            it_src_ok   <= in_src_ok;
            it_learn    <= in_src_ok && !in_src[GROUP_BIT];
            it_lookup   <= !in_dst[GROUP_BIT];
            it_dst      <= in_dst;
            it_src      <= in_src;
            it_ready    <= in_ready;
            res_deliver <= (in_cmd == CMD_FRAME && in_len_ok && !sw_en) ?
                           flood_mask(in_ready, port_count, in_src_ok, in_sel) : '0;
            res_new     <= (in_cmd == CMD_ADD && port_count < 4'(MAX_PORTS)) ?
                           port_count[2:0] : '0;
            cnt         <= '0;
            p_valid     <= 1'b0;
            m_found     <= 1'b0;
            e_found     <= 1'b0;
            o_found     <= 1'b0;
            d_found     <= 1'b0;
            o_age       <= '0;
            state       <= in_scan ? S_SCAN : S_DONE;
            unique case (in_cmd)
              CMD_FRAME: begin
                if (!in_len_ok) begin
                  dropped_total <= dropped_total + 32'd1;
                  res_status    <= ST_DROPPED;
                end else begin
                  routed_total <= routed_total + 32'd1;
                  res_status   <= ST_ROUTED;
                end
              end
              CMD_TICK: begin
                clock_ms <= clock_next;
                if (in_aging) begin
                  last_scan  <= clock_next;
                  res_status <= ST_AGED;
                end else begin
                  res_status <= ST_TICK;
                end
              end
              CMD_ADD: begin
                if (port_count >= 4'(MAX_PORTS)) begin
                  res_status <= ST_REFUSED;
                end else begin
                  port_count <= port_count + 4'd1;
                  res_status <= ST_ADDED;
                end
              end
              CMD_REMOVE: begin
                if ({1'b0, in_sel} < port_count) begin
                  res_status <= ST_REMOVED;
                end else begin
                  res_status <= ST_IGNORED;
                end
              end
              default: ;
            endcase
          end
        end

        S_SCAN: begin
          if (cnt < LAST) begin
            cnt     <= cnt + CW'(1);
            p_valid <= 1'b1;
            p_idx   <= cnt[IW-1:0];
          end else begin
            p_valid <= 1'b0;
          end
          if (!p_valid && cnt == LAST) begin
            state <= S_FIN;
          end
          if (p_valid) begin
            case (it_cmd)
              CMD_FRAME: begin
                if (!cur_v) begin
                  if (!e_found) begin
                    e_found <= 1'b1;
                    e_idx   <= p_idx;
                  end
                end else begin
                  if (rd_entry.mac == it_src) begin
                    m_found <= 1'b1;
                    m_idx   <= p_idx;
                  end else if (cur_age > o_age) begin
                    o_found <= 1'b1;
                    o_idx   <= p_idx;
                    o_age   <= cur_age;
                  end
                  if (rd_entry.mac == it_dst && !d_found) begin
                    d_found <= 1'b1;
                    d_idx   <= p_idx;
                    d_port  <= rd_entry.port;
                  end
                end
              end
              CMD_TICK: begin
                if (cur_v && cur_age > age_limit) begin
                  valid_bits[p_idx] <= 1'b0;
                end
              end
              CMD_REMOVE: begin
                if (cur_v && rd_entry.port == it_sel) begin
                  valid_bits[p_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end

        S_FIN: begin
          case (it_cmd)
            CMD_FRAME: begin
              res_deliver <= fin_deliver;
              if (slot_ok) begin
                valid_bits[slot] <= 1'b1;
              end
            end
            CMD_REMOVE: port_count <= port_count - 4'd1;
            default: ;
          endcase
          state <= S_DONE;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {1'b0, dropped_total, routed_total, port_count, res_new, res_deliver};
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/elsf_checker.sv =====
// port-level checks for the switch forwarder, bound to the top level
// depends on elsf_pkg and ethernet_learning_switch_forwarder_macros.svh
`timescale 1ns / 1ps
`include "ethernet_learning_switch_forwarder_macros.svh"

module elsf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata,
  input logic [2:0]   m_tuser
);
  import elsf_pkg::*;

  // stalled result holds
  `ELSF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // one request at a time
  `ELSF_ASSERT_NEXT(a_single, s_tvalid && s_tready, !s_tready)
  // only routed frames deliver
  `ELSF_ASSERT_NOW(a_deliver, m_tvalid && m_tuser != ST_ROUTED, m_tdata[7:0] == 8'd0)
  // new port index only on an add
  `ELSF_ASSERT_NOW(a_newport, m_tvalid && m_tuser != ST_ADDED, m_tdata[10:8] == 3'd0)
  // port count bounded
  `ELSF_ASSERT_NOW(a_live, m_tvalid, m_tdata[14:11] <= 4'(MAX_PORTS))

endmodule

bind ethernet_learning_switch_forwarder elsf_checker u_elsf_checker (.*);
